/* rtl/ocp_pkg.sv */
`timescale 1ns / 1ps

package ocp_pkg;

    localparam int MAX_FFT_LEN  = 2048;
    localparam int SAMPLE_WIDTH = 16;

    // widths derived from the buffer size
    localparam int IDX_W  = $clog2(MAX_FFT_LEN);       // index inside one bank
    localparam int LEN_W  = IDX_W + 1;                 // holds MAX_FFT_LEN itself
    localparam int ADDR_W = IDX_W + 1;                 // bank bit + index
    localparam int WORD_W = 2 * SAMPLE_WIDTH;          // packed {q, i}
    localparam int PROD_W = LEN_W + 8;                 // n * 160 fits

    localparam int CFG_W  = 12;                        // width of fft_len register

    // prefix length = floor(num * n / 2048)
    localparam int CP_FIRST_NUM = 160;
    localparam int CP_OTHER_NUM = 144;
    localparam int CP_DEN_SHIFT = 11;
    localparam logic [2:0] LAST_SYMBOL = 3'd6;

    // output queue depth
    localparam int QDEPTH = 3;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // item kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    // register map (word index)
    localparam logic REG_FFT_LEN = 1'b0;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] cp_first;
        logic [LEN_W-1:0] cp_other;
        logic [LEN_W-1:0] tot_first;
        logic [LEN_W-1:0] tot_other;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic symbol_end;
        logic slot_start;
        logic overflow;
    } s1_t;

    typedef struct packed {
        logic                           out_valid;
        logic signed [SAMPLE_WIDTH-1:0] out_i;
        logic signed [SAMPLE_WIDTH-1:0] out_q;
        logic                           symbol_end;
        logic                           slot_start;
        logic                           overflow;
    } result_t;

    // clamp the register value to 1..MAX_FFT_LEN
    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = LEN_W'(v);
        if (v == '0)
            n = LEN_W'(1);
        else if (32'(v) > MAX_FFT_LEN)
            n = LEN_W'(MAX_FFT_LEN);
        return n;
    endfunction

    function automatic logic [LEN_W-1:0] cp_len(input logic [LEN_W-1:0] n,
                                                input logic is_first);
        logic [PROD_W-1:0] prod;
        if (is_first)
            prod = PROD_W'(n) * PROD_W'(CP_FIRST_NUM);
        else
            prod = PROD_W'(n) * PROD_W'(CP_OTHER_NUM);
        return LEN_W'(prod >> CP_DEN_SHIFT);
    endfunction

endpackage

/* rtl/ocp_ram.sv */
`timescale 1ns / 1ps

module ocp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/ocp_ctrl.sv */
`timescale 1ns / 1ps

module ocp_ctrl import ocp_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    cfg_clear,
    input  logic                    accept,
    input  logic                    kind,
    input  logic [SAMPLE_WIDTH-1:0] sample_i,
    input  logic [SAMPLE_WIDTH-1:0] sample_q,
    output ram_req_t                ram_req,
    output s1_t                     s1
);

    logic [1:0]       bank_full_reg,      bank_full_next;
    logic             write_bank_reg,     write_bank_next;
    logic [IDX_W-1:0] write_index_reg,    write_index_next;
    logic             read_bank_reg,      read_bank_next;
    logic [LEN_W-1:0] read_position_reg,  read_position_next;
    logic [2:0]       symbol_in_slot_reg, symbol_in_slot_next;
    s1_t              s1_reg,             s1_next;

    logic             first;
    logic [LEN_W-1:0] cp;
    logic [LEN_W-1:0] total;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] sidx;
    logic [LEN_W-1:0] widx;

    always_comb
    begin
        first = (symbol_in_slot_reg == '0);
        cp    = first ? cfg.cp_first  : cfg.cp_other;
        total = first ? cfg.tot_first : cfg.tot_other;
        pos   = (read_position_reg >= total) ? total - LEN_W'(1) : read_position_reg;
        sidx  = (pos < cp) ? (cfg.len - cp + pos) : (pos - cp);
        widx  = (LEN_W'(write_index_reg) >= cfg.len) ? cfg.len - LEN_W'(1)
                                                     : LEN_W'(write_index_reg);
    end

    always_comb
    begin
        bank_full_next      = bank_full_reg;
        write_bank_next     = write_bank_reg;
        write_index_next    = write_index_reg;
        read_bank_next      = read_bank_reg;
        read_position_next  = read_position_reg;
        symbol_in_slot_next = symbol_in_slot_reg;
        s1_next             = '0;
        ram_req.we          = 1'b0;
        ram_req.addr        = {read_bank_reg, sidx[IDX_W-1:0]};
        ram_req.wdata       = {sample_q, sample_i};

        if (accept)
        begin
            s1_next.valid = 1'b1;
            if (kind == KIND_PUSH)
            begin
                if (bank_full_reg[write_bank_reg])
                begin
                    s1_next.overflow = 1'b1;
                end
                else
                begin
                    ram_req.we   = 1'b1;
                    ram_req.addr = {write_bank_reg, widx[IDX_W-1:0]};
                    if (widx + LEN_W'(1) >= cfg.len)
                    begin
                        bank_full_next[write_bank_reg] = 1'b1;
                        write_bank_next  = ~write_bank_reg;
                        write_index_next = '0;
                    end
                    else
                    begin
                        write_index_next = IDX_W'(widx + LEN_W'(1));
                    end
                end
            end
            else if (bank_full_reg[read_bank_reg])
            begin
                s1_next.hit        = 1'b1;
                s1_next.slot_start = first && (pos == '0);
                if (pos + LEN_W'(1) >= total)
                begin
                    s1_next.symbol_end = 1'b1;
                    bank_full_next[read_bank_reg] = 1'b0;
                    read_bank_next      = ~read_bank_reg;
                    read_position_next  = '0;
                    symbol_in_slot_next = (symbol_in_slot_reg >= LAST_SYMBOL)
                                          ? 3'd0 : symbol_in_slot_reg + 3'd1;
                end
                else
                begin
                    read_position_next = pos + LEN_W'(1);
                end
            end
        end

        if (cfg_clear)
        begin
            bank_full_next      = '0;
            write_bank_next     = 1'b0;
            write_index_next    = '0;
            read_bank_next      = 1'b0;
            read_position_next  = '0;
            symbol_in_slot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_full_reg      <= '0;
            write_bank_reg     <= 1'b0;
            write_index_reg    <= '0;
            read_bank_reg      <= 1'b0;
            read_position_reg  <= '0;
            symbol_in_slot_reg <= '0;
            s1_reg             <= '0;
        end
        else
        begin
            bank_full_reg      <= bank_full_next;
            write_bank_reg     <= write_bank_next;
            write_index_reg    <= write_index_next;
            read_bank_reg      <= read_bank_next;
            read_position_reg  <= read_position_next;
            symbol_in_slot_reg <= symbol_in_slot_next;
            s1_reg             <= s1_next;
        end
    end

    assign s1 = s1_reg;

    // a full write bank means the reader still owns the other one too
    a_full_pair: assert property (@(posedge clk) disable iff (!rst_n)
        bank_full_reg[write_bank_reg] |-> bank_full_reg == 2'b11)
        else $error("write bank full while other bank free");

    a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_in_slot_reg <= LAST_SYMBOL)
        else $error("symbol counter out of range");

    a_s1_follow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_reg.valid)
        else $error("transfer lost before read stage");

    a_hit_src: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.hit |-> $past(bank_full_reg[read_bank_reg]))
        else $error("read from a bank that was not full");

endmodule

/* rtl/ocp_outq.sv */
`timescale 1ns / 1ps

module ocp_outq import ocp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  result_t           din,
    input  logic              rsp_stall,
    output logic              rsp_valid,
    output result_t           dout,
    output logic [QCNT_W-1:0] count
);

    result_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic              pop;

    assign rsp_valid = (count_reg != '0);
    assign pop       = rsp_valid && !rsp_stall;
    assign dout      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (32'(count_reg) < QDEPTH) || pop)
        else $error("result queue overrun");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QDEPTH)
        else $error("result queue count out of range");

    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

/* rtl/ofdm_cyclic_prefix_inserter.sv */
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// in        in_valid / in_stall       kind, sample_i, sample_q
// rsp       rsp_valid / rsp_stall     out_valid, out_i, out_q, symbol_end,
//                                     slot_start, overflow
// cfg       APB psel/penable/pready   paddr, pwdata, prdata (fft_len at 0x0)
//
// One transfer per clock while in_stall is low; every input transfer gives one
// result transfer, through the sample RAM stage and then the result queue.
// The single-port sample RAM takes one push write or one pull read per cycle.
// Reset is asynchronous and clears control state only; the sample RAM is
// left as it is, unwritten entries are never read.
// A three-entry result queue absorbs rsp_stall; in_stall rises only when
// the queue plus the transfer in the RAM stage would fill it.

module ofdm_cyclic_prefix_inserter import ocp_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input items
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_q,
    // results
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] out_i,
    output logic signed [SAMPLE_WIDTH-1:0] out_q,
    output logic                           symbol_end,
    output logic                           slot_start,
    output logic                           overflow
);

    logic [CFG_W-1:0]  fft_len_reg;
    cfg_t              cfg_reg, cfg_next;
    logic              cfg_wr;
    logic              accept;
    ram_req_t          ram_req;
    logic [WORD_W-1:0] ram_rdata;
    s1_t               s1;
    result_t           res;
    result_t           head;
    logic [QCNT_W-1:0] q_count;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FFT_LEN);
    assign prdata = (paddr[2] == REG_FFT_LEN) ? 32'(fft_len_reg) : '0;

    // prefix lengths are worked out once, when fft_len is written
    always_comb
    begin
        cfg_next.len       = clamp_len(pwdata[CFG_W-1:0]);
        cfg_next.cp_first  = cp_len(cfg_next.len, 1'b1);
        cfg_next.cp_other  = cp_len(cfg_next.len, 1'b0);
        cfg_next.tot_first = cfg_next.cp_first + cfg_next.len;
        cfg_next.tot_other = cfg_next.cp_other + cfg_next.len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fft_len_reg       <= CFG_W'(MAX_FFT_LEN);
            cfg_reg.len       <= LEN_W'(MAX_FFT_LEN);
            cfg_reg.cp_first  <= LEN_W'((CP_FIRST_NUM * MAX_FFT_LEN) >> CP_DEN_SHIFT);
            cfg_reg.cp_other  <= LEN_W'((CP_OTHER_NUM * MAX_FFT_LEN) >> CP_DEN_SHIFT);
            cfg_reg.tot_first <= LEN_W'(((CP_FIRST_NUM * MAX_FFT_LEN) >> CP_DEN_SHIFT)
                                        + MAX_FFT_LEN);
            cfg_reg.tot_other <= LEN_W'(((CP_OTHER_NUM * MAX_FFT_LEN) >> CP_DEN_SHIFT)
                                        + MAX_FFT_LEN);
        end
        else if (cfg_wr)
        begin
            fft_len_reg <= pwdata[CFG_W-1:0];
            cfg_reg     <= cfg_next;
        end
    end

    // ---- input side: room for the RAM-stage transfer plus the new one ----
    assign in_stall = (QCNT_W'(q_count + QCNT_W'(s1.valid)) >= QCNT_W'(QDEPTH));
    assign accept   = in_valid && !in_stall;

    ocp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_wr),
        .accept    (accept),
        .kind      (kind),
        .sample_i  (sample_i),
        .sample_q  (sample_q),
        .ram_req   (ram_req),
        .s1        (s1)
    );

    // two banks of MAX_FFT_LEN packed {q, i} words
    ocp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (2 * MAX_FFT_LEN)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // ---- result assembly: RAM data only on a pull that found a full bank ----
    always_comb
    begin
        res.out_valid  = s1.hit;
        res.out_i      = s1.hit ? ram_rdata[SAMPLE_WIDTH-1:0] : '0;
        res.out_q      = s1.hit ? ram_rdata[WORD_W-1:SAMPLE_WIDTH] : '0;
        res.symbol_end = s1.symbol_end;
        res.slot_start = s1.slot_start;
        res.overflow   = s1.overflow;
    end

    ocp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1.valid),
        .din       (res),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .dout      (head),
        .count     (q_count)
    );

    assign out_valid  = head.out_valid;
    assign out_i      = head.out_i;
    assign out_q      = head.out_q;
    assign symbol_end = head.symbol_end;
    assign slot_start = head.slot_start;
    assign overflow   = head.overflow;

endmodule
